// ----- rtl/core/csbr_pkg.sv -----
// shared constants and types for the clocked serial bit receiver
package csbr_pkg;

    localparam int unsigned REG_W       = 16;
    localparam int unsigned POS_W       = 3;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned LEN_W       = 12;

    localparam logic [POS_W-1:0]  TOP_BIT       = 3'd7;
    localparam logic [BYTE_W-1:0] NEWLINE       = 8'h0A;
    localparam logic [LEN_W-1:0]  LEN_FIELD_MAX = 12'hFFF;
    localparam logic [REG_W-1:0]  ELAPSED_MAX   = 16'hFFFF;

    localparam logic [REG_W-1:0]  MIN_BIT_MS_RST      = 16'd10;
    localparam logic [REG_W-1:0]  BYTE_TIMEOUT_MS_RST = 16'd500;

    // configuration register index
    typedef enum logic [0:0] {
        CFG_MIN_BIT_MS      = 1'b0,
        CFG_BYTE_TIMEOUT_MS = 1'b1
    } t_cfg_idx;

    // flags carried on the result tuser
    typedef struct packed {
        logic timeout_seen;
        logic byte_valid;
        logic bit_valid;
    } t_out_flags;

    // result tdata fields
    typedef struct packed {
        logic [LEN_W-1:0]  line_length;
        logic [BYTE_W-1:0] byte_value;
        logic              bit_value;
    } t_out_data;

endpackage

// ----- rtl/core/clocked_serial_bit_receiver_top.sv -----
// two-wire clock/data serial receiver, msb first, one pin sample per word
//
// usage:
//   s_axis carries one pin sample per word: clock pin, data pin (both active
//   low) and a millisecond tick. every accepted word yields exactly one result
//   word on m_axis; samples without a clock edge give an all-zero result.
//   m_axis tuser flags a received bit, a completed byte and a timeout resync;
//   tdata holds the bit, the byte and, with tlast, the length of a line that
//   ended in newline.
//   user writes min_bit_ms, byte_timeout_ms over the cfg port only while idle; not enforced.
// timing and throughput:
//   a result is registered in the cycle after its sample is accepted; one sample
//   per cycle is taken while the result register can be drained, and the
//   edge/compare logic that updates the receiver state is combinational.
// reset:
//   synchronous, active low; clock inactive, bit position seven, counters and
//   bytes cleared, registers back to 10 ms and 500 ms.
// stall:
//   the result register holds while m_axis_tready is low; s_axis_tready drops
//   only while that register is full and not being drained
module clocked_serial_bit_receiver_top #(
    parameter int unsigned MAX_LINE_BYTES = 4095
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration write port
    input  logic                      i_cfg_we,
    input  csbr_pkg::t_cfg_idx        i_cfg_idx,
    input  logic [csbr_pkg::REG_W-1:0] i_cfg_data,
    // sample input
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [7:0]                s_axis_tdata,  // clock_pin, data_pin, ms_tick, zero pad
    // result output
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [23:0]               m_axis_tdata,  // bit_value, byte_value[7:0],
                                                     // line_length[11:0], zero pad
    output logic [2:0]                m_axis_tuser,  // bit_valid, byte_valid, timeout_seen
    output logic                      m_axis_tlast   // line_end
);
    import csbr_pkg::*;

    localparam int unsigned LB_W = $clog2(MAX_LINE_BYTES + 1);
    localparam logic [LB_W-1:0] LB_MAX = LB_W'(MAX_LINE_BYTES);

    // configuration
    logic [REG_W-1:0] r_min_bit_ms;
    logic [REG_W-1:0] r_byte_timeout_ms;

    // receiver state
    logic              r_clk_act,  n_clk_act;
    logic [REG_W-1:0]  r_elapsed,  n_elapsed;
    logic [BYTE_W-1:0] r_pending,  n_pending;
    logic [BYTE_W-1:0] r_accepted, n_accepted;
    logic [POS_W-1:0]  r_bit_pos,  n_bit_pos;
    logic [LB_W-1:0]   r_line_bytes, n_line_bytes;

    // result register
    logic       r_out_valid;
    t_out_flags r_out_flags, n_out_flags;
    t_out_data  r_out_data,  n_out_data;
    logic       r_out_last,  n_out_last;

    // per-sample decode
    logic              act, dbit, tick, in_fire, clk_edge;
    logic [REG_W-1:0]  el_tick;
    logic              timed_out, bit_ok;
    logic [POS_W-1:0]  pos_a;
    logic [BYTE_W-1:0] pend_a;
    logic [LB_W-1:0]   lb_inc;

    assign act  = ~s_axis_tdata[0];
    assign dbit = ~s_axis_tdata[1];
    assign tick = s_axis_tdata[2];

    // result register drains or is empty, so a new sample can land
    assign s_axis_tready = ~r_out_valid | m_axis_tready;
    assign in_fire       = s_axis_tvalid & s_axis_tready;

    assign clk_edge  = act != r_clk_act;
    // tick is counted before the edge is judged
    assign el_tick   = (tick && r_elapsed != ELAPSED_MAX) ? r_elapsed + 16'd1 : r_elapsed;
    assign timed_out = el_tick > r_byte_timeout_ms;
    assign bit_ok    = el_tick >= r_min_bit_ms;

    // resync keeps the bit at the old position, moved up to bit seven
    assign pos_a  = timed_out ? TOP_BIT : r_bit_pos;
    assign pend_a = timed_out ? {r_pending[r_bit_pos], 7'd0} : r_pending;

    assign lb_inc = (r_line_bytes < LB_MAX) ? r_line_bytes + LB_W'(1) : r_line_bytes;

    always_comb begin
        n_clk_act    = r_clk_act;
        n_elapsed    = el_tick;
        n_pending    = r_pending;
        n_accepted   = r_accepted;
        n_bit_pos    = r_bit_pos;
        n_line_bytes = r_line_bytes;
        n_out_flags  = '0;
        n_out_data   = '0;
        n_out_last   = 1'b0;

        if (clk_edge) begin
            n_clk_act = act;
            if (act) begin
                // clock went active: latch the data bit
                n_pending            = r_pending;
                n_pending[r_bit_pos] = dbit;
            end else begin
                n_out_flags.timeout_seen = timed_out;
                n_bit_pos                = pos_a;
                if (bit_ok) begin
                    n_pending             = pend_a;
                    n_accepted            = pend_a;
                    n_out_flags.bit_valid = 1'b1;
                    n_out_data.bit_value  = pend_a[pos_a];
                    n_elapsed             = '0;
                    if (pos_a == '0) begin
                        n_out_flags.byte_valid = 1'b1;
                        n_out_data.byte_value  = pend_a;
                        n_accepted             = '0;
                        n_bit_pos              = TOP_BIT;
                        n_line_bytes           = lb_inc;
                        if (pend_a == NEWLINE) begin
                            n_out_last = 1'b1;
                            n_out_data.line_length =
                                (32'(lb_inc) > 32'(LEN_FIELD_MAX)) ? LEN_FIELD_MAX
                                                                    : LEN_W'(lb_inc);
                            n_line_bytes = '0;
                        end
                    end else begin
                        n_bit_pos = pos_a - 3'd1;
                    end
                end else begin
                    // glitch: drop the partial bit
                    n_pending = r_accepted;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_bit_ms      <= MIN_BIT_MS_RST;
            r_byte_timeout_ms <= BYTE_TIMEOUT_MS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_BIT_MS:      r_min_bit_ms      <= i_cfg_data;
                CFG_BYTE_TIMEOUT_MS: r_byte_timeout_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_act    <= 1'b0;
            r_elapsed    <= '0;
            r_pending    <= '0;
            r_accepted   <= '0;
            r_bit_pos    <= TOP_BIT;
            r_line_bytes <= '0;
        end else if (in_fire) begin
            r_clk_act    <= n_clk_act;
            r_elapsed    <= n_elapsed;
            r_pending    <= n_pending;
            r_accepted   <= n_accepted;
            r_bit_pos    <= n_bit_pos;
            r_line_bytes <= n_line_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_flags <= n_out_flags;
            r_out_data  <= n_out_data;
            r_out_last  <= n_out_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_flags;
    assign m_axis_tdata  = {3'd0, r_out_data};
    assign m_axis_tlast  = r_out_last;

`ifndef ASSERT_OFF
    // a completed byte always comes with its last bit
    a_byte_has_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_flags.byte_valid |-> r_out_flags.bit_valid)
        else $error("byte reported without its bit");

    // line end only on a completed newline byte
    a_line_end_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_last |->
            r_out_flags.byte_valid && r_out_data.byte_value == NEWLINE)
        else $error("line end without newline byte");

    // a sample without a clock edge gives an empty result
    a_no_edge_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && !clk_edge |=> r_out_flags == '0 && !r_out_last)
        else $error("result flags set without a clock edge");

    // a byte completion resets the bit position
    a_byte_resets_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && n_out_flags.byte_valid |=> r_bit_pos == TOP_BIT)
        else $error("bit position not back at top after byte");

    // line byte count never passes its limit
    a_line_bytes_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_bytes <= LB_MAX)
        else $error("line byte count overflow");
`endif

endmodule

// ----- verif/tb_clocked_serial_bit_receiver_top.sv -----
// self-checking testbench for the clocked serial bit receiver, driven from a queue of pin samples
`timescale 1ns / 1ps

module tb_clocked_serial_bit_receiver_top;
    import csbr_pkg::*;

    localparam int unsigned LINE_BYTES_MAX = 4095;
    localparam int          STALL_LIMIT    = 2000;   // cycles without any handshake
    localparam int          LONG_HOLD      = 400;    // receiver hold-off for back-pressure
    localparam int          DRAIN_CYCLES   = 4;      // covers the result register plus margin

    // one pin sample as it sits in the low bits of s_axis_tdata
    typedef struct packed {
        logic ms_tick;
        logic data_pin;
        logic clock_pin;
    } pin_sample_t;

    // what one result word should carry
    typedef struct packed {
        logic              bit_valid;
        logic              bit_value;
        logic              byte_valid;
        logic [BYTE_W-1:0] byte_value;
        logic              line_end;
        logic [LEN_W-1:0]  line_length;
        logic              timeout_seen;
    } rx_result_t;

    // dut connections, inputs known from time zero
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    t_cfg_idx             i_cfg_idx     = CFG_MIN_BIT_MS;
    logic [REG_W-1:0]     i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = '0;  // clock_pin, data_pin, ms_tick, zero pad
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [23:0]          m_axis_tdata;        // bit_value, byte_value, line_length, zero pad
    logic [2:0]           m_axis_tuser;        // bit_valid, byte_valid, timeout_seen
    logic                 m_axis_tlast;        // line_end

    // pending pin samples and predicted result words
    pin_sample_t sample_q[$];
    rx_result_t  rx_result_q[$];

    // predictor copy of the registers and receiver state
    logic [REG_W-1:0]  min_ms;
    logic [REG_W-1:0]  timeout_ms;
    logic              clk_active;
    logic [REG_W-1:0]  ms_count;
    logic [BYTE_W-1:0] shift_byte;
    logic [BYTE_W-1:0] held_byte;
    logic [POS_W-1:0]  bit_pos;
    logic [15:0]       line_count;

    // run control
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    int mismatches    = 0;
    int stall_cycles  = 0;

    clocked_serial_bit_receiver_top #(
        .MAX_LINE_BYTES (LINE_BYTES_MAX)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // receiver state after reset
    function automatic void rx_reset();
        min_ms     = MIN_BIT_MS_RST;
        timeout_ms = BYTE_TIMEOUT_MS_RST;
        clk_active = 1'b0;
        ms_count   = '0;
        shift_byte = '0;
        held_byte  = '0;
        bit_pos    = TOP_BIT;
        line_count = '0;
    endfunction

    // advance the receiver by one pin sample and return the word it produces
    function automatic rx_result_t decode_pin_sample(input pin_sample_t smp);
        rx_result_t r;
        logic       act;
        logic       dbit;
        logic       keep;
        r    = '0;
        act  = ~smp.clock_pin;
        dbit = ~smp.data_pin;
        // the tick lands before the edge is looked at
        if (smp.ms_tick && ms_count != ELAPSED_MAX)
            ms_count++;
        if (act != clk_active) begin
            clk_active = act;
            if (act) begin
                shift_byte[bit_pos] = dbit;
            end else begin
                // long gap: keep only the current bit, moved up to bit seven
                if (ms_count > timeout_ms) begin
                    keep           = shift_byte[bit_pos];
                    bit_pos        = TOP_BIT;
                    shift_byte     = {keep, 7'b0};
                    r.timeout_seen = 1'b1;
                end
                if (ms_count >= min_ms) begin
                    held_byte   = shift_byte;
                    r.bit_valid = 1'b1;
                    r.bit_value = held_byte[bit_pos];
                    if (bit_pos == '0) begin
                        r.byte_valid = 1'b1;
                        r.byte_value = held_byte;
                        if (line_count < LINE_BYTES_MAX)
                            line_count++;
                        if (held_byte == NEWLINE) begin
                            r.line_end    = 1'b1;
                            r.line_length = (line_count > LEN_FIELD_MAX) ? LEN_FIELD_MAX
                                                                         : line_count[LEN_W-1:0];
                            line_count    = '0;
                        end
                        bit_pos   = TOP_BIT;
                        held_byte = '0;
                    end else begin
                        bit_pos--;
                    end
                    ms_count = '0;
                end else begin
                    // too short: a glitch, undo the sampled bit
                    shift_byte = held_byte;
                end
            end
        end
        return r;
    endfunction

    // sender: one sample word per handshake, random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                rx_result_q.push_back(decode_pin_sample(pin_sample_t'(s_axis_tdata[2:0])));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (sample_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_axis_tdata  <= {5'b0, sample_q.pop_front()};
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: want 0x%0h got 0x%0h at %0t ns", what, want, got, $time);
        end
    endtask

    // receiver: compare each result word with the oldest prediction, random stalls
    always @(posedge i_clk) begin : result_check
        t_out_flags fl;
        t_out_data  dt;
        rx_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            fl = t_out_flags'(m_axis_tuser);
            dt = t_out_data'(m_axis_tdata[20:0]);
            if (rx_result_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result word with nothing pending at %0t ns", $time);
            end else begin
                want = rx_result_q.pop_front();
                check_field("bit_valid",    want.bit_valid,    fl.bit_valid);
                check_field("bit_value",    want.bit_value,    dt.bit_value);
                check_field("byte_valid",   want.byte_valid,   fl.byte_valid);
                check_field("byte_value",   want.byte_value,   dt.byte_value);
                check_field("line_end",     want.line_end,     m_axis_tlast);
                check_field("line_length",  want.line_length,  dt.line_length);
                check_field("timeout_seen", want.timeout_seen, fl.timeout_seen);
            end
        end
        // a long hold-off wins over the random stalls
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles where nothing moves
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic push_sample(input logic clock_pin, input logic data_pin, input logic tick);
        pin_sample_t smp;
        smp.clock_pin = clock_pin;
        smp.data_pin  = data_pin;
        smp.ms_tick   = tick;
        sample_q.push_back(smp);
    endtask

    // one clock pulse: ticks while idle, falling clock pin with the data, then release
    task automatic send_bit(input logic value, input int ticks, input bit quick);
        repeat (ticks) push_sample(1'b1, 1'($urandom_range(1)), 1'b1);
        push_sample(1'b0, ~value, quick ? 1'b0 : 1'($urandom_range(9) == 0));
        if (!quick)
            repeat ($urandom_range(2)) push_sample(1'b0, 1'($urandom_range(1)), 1'b0);
        push_sample(1'b1, 1'($urandom_range(1)), 1'b0);
    endtask

    // ticks before a bit: mostly valid spacing, some glitches, some timeouts when the timeout is below 40
    function automatic int pick_ticks();
        int r;
        r = $urandom_range(99);
        if (r < 75)
            return min_ms + $urandom_range(1);
        if (r < 88)
            return (min_ms == 0) ? 0 : $urandom_range(min_ms - 1);
        if (timeout_ms < 40)
            return timeout_ms + 1 + $urandom_range(2);
        return min_ms;
    endfunction

    task automatic send_byte(input logic [7:0] value, input int nbits, input bit quick);
        for (int i = 7; i > 7 - nbits; i--)
            send_bit(value[i], quick ? 0 : pick_ticks(), quick);
    endtask

    // random bytes with newlines, broken bytes and raw noise
    task automatic fill_random(input int budget);
        int start;
        int r;
        start = sample_q.size();
        while (sample_q.size() - start < budget) begin
            r = $urandom_range(99);
            if (r < 80 && min_ms <= 40) begin
                send_byte(($urandom_range(4) == 0) ? NEWLINE : 8'($urandom_range(255)), 8, 0);
            end else if (r < 90 && min_ms <= 40) begin
                send_byte(8'($urandom_range(255)), $urandom_range(1, 7), 0);
            end else begin
                repeat ($urandom_range(1, 8))
                    push_sample(1'($urandom_range(1)), 1'($urandom_range(1)),
                                1'($urandom_range(1)));
            end
        end
    endtask

    // wait until every sample went in and every result came out
    task automatic wait_drained();
        while (sample_q.size() > 0 || s_axis_tvalid || rx_result_q.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input t_cfg_idx idx, input logic [REG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_MIN_BIT_MS:      min_ms     = value;
            CFG_BYTE_TIMEOUT_MS: timeout_ms = value;
            default: ;
        endcase
    endtask

    // new register setting and idle mix while the block is empty
    task automatic set_phase(input logic [REG_W-1:0] mn, input logic [REG_W-1:0] tmo,
                             input int sidle, input int ridle);
        wait_drained();
        reg_write(CFG_MIN_BIT_MS, mn);
        reg_write(CFG_BYTE_TIMEOUT_MS, tmo);
        @(negedge i_clk);
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
    endtask

    initial begin
        rx_reset();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: short spacing so each case takes few samples
        set_phase(16'd1, 16'd2, 0, 0);
        push_sample(1'b1, 1'b1, 1'b0);   // no clock edge
        push_sample(1'b0, 1'b0, 1'b0);   // clock goes active, data one
        push_sample(1'b1, 1'b1, 1'b0);   // release too soon: glitch
        push_sample(1'b0, 1'b0, 1'b1);   // tick on the edge sample counts first
        push_sample(1'b1, 1'b0, 1'b0);   // accepted, bit seven
        push_sample(1'b1, 1'b1, 1'b1);
        push_sample(1'b1, 1'b0, 1'b1);
        push_sample(1'b1, 1'b1, 1'b1);   // gap now past the timeout
        push_sample(1'b0, 1'b1, 1'b0);   // data zero
        push_sample(1'b1, 1'b1, 1'b0);   // resync to bit seven and accept
        for (int i = 6; i >= 0; i--)      // finish a newline byte, one tick per bit
            send_bit(NEWLINE[i], 1, 1);

        // random phases through register extremes and the idle mixes
        set_phase(16'd0, 16'd0, 0, 0);
        fill_random(90);
        set_phase(16'd1, 16'd3, 61, 0);
        fill_random(90);
        set_phase(16'd2, 16'd5, 0, 61);
        fill_random(90);
        // receiver holds off while the sender keeps offering
        @(negedge i_clk);
        hold_left = LONG_HOLD;
        set_phase(16'd3, 16'd1, 10, 10);  // minimum above the timeout
        fill_random(90);
        set_phase(ELAPSED_MAX, 16'd0, 61, 61);
        fill_random(50);
        set_phase(16'd0, ELAPSED_MAX, 10, 10);
        fill_random(90);
        set_phase(MIN_BIT_MS_RST, BYTE_TIMEOUT_MS_RST, 61, 0);
        fill_random(150);

        wait_drained();
        if (mismatches == 0 && rx_result_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
